### hdl/npcl_pkg.sv
// Package for the nearest-point coil lookup: payload structs, sizes, kind codes.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package npcl_pkg;
   localparam int NumModes       = 4;
   localparam int EntriesPerMode = 256;
   localparam int StoreDepth     = NumModes * EntriesPerMode;
   localparam int IdxBits        = $clog2(EntriesPerMode);
   localparam int CntBits        = $clog2(EntriesPerMode + 1);
   localparam int AddrBits       = $clog2(StoreDepth);
   localparam int DistBits       = 33;
   localparam int NumCells       = 2;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         mode;
      logic [15:0]        gap;
      logic [15:0]        phase;
      logic signed [15:0] coil_a;
      logic signed [15:0] coil_b;
      logic signed [15:0] coil_c;
      logic signed [15:0] coil_d;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [7:0]         match_index;
      logic signed [15:0] out_coil_a;
      logic signed [15:0] out_coil_b;
      logic signed [15:0] out_coil_c;
      logic signed [15:0] out_coil_d;
   } rsp_type;

   // Candidate handed from cell to cell along the scan chain
   typedef struct packed {
      logic                valid;
      logic                last;
      logic [IdxBits-1:0]  index;
      logic [15:0]         gap;
      logic [15:0]         phase;
      logic [DistBits-1:0] sq_dist;
   } cand_type;

   // Running best carried alongside the candidate
   typedef struct packed {
      logic                have;
      logic [IdxBits-1:0]  index;
      logic [DistBits-1:0] sq_dist;
   } best_type;
endpackage

### hdl/npcl_cell.sv
// One scan cell: computes a distance term or folds a candidate into the best.
// Depends on npcl_pkg.
`timescale 1ns / 1ps
module npcl_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               stage_sel,
   input  logic [15:0]        q_gap,
   input  logic [15:0]        q_phase,
   input  npcl_pkg::cand_type cand_in,
   input  npcl_pkg::best_type best_in,
   output npcl_pkg::cand_type cand_out,
   output npcl_pkg::best_type best_out
);
   import npcl_pkg::*;

   cand_type cand_ff, cand_in_c;
   best_type best_ff, best_in_c;
   logic [15:0] dg, dp;
   logic [31:0] sq_g, sq_p;

   // Stage 0: squared deltas; stage 1: compare against running best
   always_comb begin
      dg = (cand_in.gap > q_gap) ? cand_in.gap - q_gap : q_gap - cand_in.gap;
      dp = (cand_in.phase > q_phase) ? cand_in.phase - q_phase : q_phase - cand_in.phase;
      sq_g = 32'(dg) * 32'(dg);
      sq_p = 32'(dp) * 32'(dp);
      cand_in_c = cand_in;
      best_in_c = best_in;
      if (!stage_sel) begin
         cand_in_c.sq_dist = DistBits'(sq_g) + DistBits'(sq_p);
      end else if (cand_in.valid && (!best_in.have || cand_in.sq_dist < best_in.sq_dist)) begin
         best_in_c.have    = 1'b1;
         best_in_c.index   = cand_in.index;
         best_in_c.sq_dist = cand_in.sq_dist;
      end
   end

   // Advance both words every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff.valid <= 1'b0;
         cand_ff.last  <= 1'b0;
      end else begin
         cand_ff.valid <= cand_in_c.valid;
         cand_ff.last  <= cand_in_c.last;
      end
      cand_ff.index   <= cand_in_c.index;
      cand_ff.gap     <= cand_in_c.gap;
      cand_ff.phase   <= cand_in_c.phase;
      cand_ff.sq_dist <= cand_in_c.sq_dist;
      best_ff         <= best_in_c;
   end

   // Pass the running best straight through a distance cell so the compare loop
   // closes through a single best register
   assign cand_out = cand_ff;
   assign best_out = stage_sel ? best_ff : best_in;
endmodule

### hdl/nearest_point_coil_lookup_core.sv
// Top level: tables, scan sequencer, cell chain and result register.
// Depends on npcl_pkg and npcl_cell.
`timescale 1ns / 1ps
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_data (req_type)
//  rsp     | out       | rsp_valid/rsp_stall | rsp_data (rsp_type)
//  csr     | in        | csr_write           | csr_data (compensate_enable)
// Clear, append and ignored items are done at their transfer. A query scans its
// mode's table before it offers its result:
// one entry per cycle is read from the position memory and sent through the
// two-cell compare chain, then the current memory is read once.
// Reset is synchronous; it empties all tables. A held rsp_stall keeps the result
// and blocks the next item until it is transferred.
module nearest_point_coil_lookup_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  npcl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output npcl_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic              csr_data
);
   import npcl_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_READ = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic enable_ff;
   logic [CntBits-1:0] count_ff [NumModes];
   logic [31:0] pos_mem [StoreDepth];
   logic [63:0] cur_mem [StoreDepth];
   logic [31:0] pos_rd_ff;
   logic [63:0] cur_rd_ff;
   logic [1:0]  mode_ff;
   logic [15:0] q_gap_ff, q_phase_ff;
   logic [CntBits-1:0] scan_ff;
   logic [CntBits-1:0] n_sel;
   logic rd_valid_ff, rd_last_ff;
   logic [IdxBits-1:0] rd_index_ff;
   best_type best_ff;
   rsp_type  rsp_ff;
   logic     rsp_valid_ff;
   logic     accept, is_append, is_query;
   logic     scan_fire;
   logic [AddrBits-1:0] wr_addr, rd_addr;
   cand_type cand_chain [NumCells+1];
   best_type best_chain [NumCells+1];

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign n_sel     = count_ff[req_data.mode];
   assign is_append = accept && req_data.kind == KIND_APPEND && n_sel < CntBits'(EntriesPerMode);
   assign is_query  = accept && req_data.kind == KIND_QUERY && enable_ff;
   assign scan_fire = (state_ff == ST_SCAN) && scan_ff < count_ff[mode_ff];
   assign wr_addr   = {req_data.mode, n_sel[IdxBits-1:0]};
   assign rd_addr   = (state_ff == ST_READ) ? {mode_ff, best_ff.index}
                                            : {mode_ff, scan_ff[IdxBits-1:0]};

   // Table memories: one write port, registered read
   always_ff @(posedge clock) begin
      if (is_append) begin
         pos_mem[wr_addr] <= {req_data.gap, req_data.phase};
         cur_mem[wr_addr] <= {req_data.coil_a, req_data.coil_b,
                              req_data.coil_c, req_data.coil_d};
      end
      pos_rd_ff <= pos_mem[rd_addr];
      cur_rd_ff <= cur_mem[rd_addr];
   end

   // Control: counts, enable, sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (is_query) state_in = ST_SCAN;
         ST_SCAN:  if (!scan_fire) state_in = ST_DRAIN;
         ST_DRAIN: if (!rd_valid_ff && !cand_chain[1].valid && !cand_chain[2].valid)
                      state_in = ST_READ;
         ST_READ:  state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         for (int m = 0; m < NumModes; m++) count_ff[m] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write) enable_ff <= csr_data;
         if (accept && req_data.kind == KIND_CLEAR)
            for (int m = 0; m < NumModes; m++) count_ff[m] <= '0;
         if (is_append) count_ff[req_data.mode] <= n_sel + 1'b1;
         rd_valid_ff <= scan_fire;
         if (state_ff == ST_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Hold query, step scan index, capture best at chain end
   always_ff @(posedge clock) begin
      if (is_query) begin
         mode_ff    <= req_data.mode;
         q_gap_ff   <= req_data.gap;
         q_phase_ff <= req_data.phase;
         scan_ff    <= '0;
      end else if (scan_fire) begin
         scan_ff <= scan_ff + 1'b1;
      end
      rd_index_ff <= scan_ff[IdxBits-1:0];
      rd_last_ff  <= 1'b0;
      if (state_ff == ST_DRAIN) best_ff <= best_chain[NumCells];
      if (state_ff == ST_OUT) begin
         rsp_ff.found       <= best_ff.have;
         rsp_ff.match_index <= best_ff.have ? 8'(best_ff.index) : 8'd0;
         rsp_ff.out_coil_a  <= best_ff.have ? cur_rd_ff[63:48] : '0;
         rsp_ff.out_coil_b  <= best_ff.have ? cur_rd_ff[47:32] : '0;
         rsp_ff.out_coil_c  <= best_ff.have ? cur_rd_ff[31:16] : '0;
         rsp_ff.out_coil_d  <= best_ff.have ? cur_rd_ff[15:0]  : '0;
      end
   end

   // Feed chain; running best loops back from the chain end
   always_comb begin
      cand_chain[0].valid   = rd_valid_ff;
      cand_chain[0].last    = rd_last_ff;
      cand_chain[0].index   = rd_index_ff;
      cand_chain[0].gap     = pos_rd_ff[31:16];
      cand_chain[0].phase   = pos_rd_ff[15:0];
      cand_chain[0].sq_dist = '0;
      best_chain[0]         = (state_ff == ST_SCAN && scan_ff == '0) ? '0 : best_chain[NumCells];
   end

   for (genvar c = 0; c < NumCells; c++) begin : g_cell
      npcl_cell u_cell (
         .clock(clock), .reset(reset), .stage_sel(c != 0),
         .q_gap(q_gap_ff), .q_phase(q_phase_ff),
         .cand_in(cand_chain[c]), .best_in(best_chain[c]),
         .cand_out(cand_chain[c+1]), .best_out(best_chain[c+1])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !accept) else $error("accept while busy");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_fire |-> scan_ff < CntBits'(EntriesPerMode)) else $error("scan overrun");
   a_out_follows: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |=> rsp_valid_ff) else $error("result lost");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      n_sel <= CntBits'(EntriesPerMode)) else $error("count overflow");
endmodule
